>>> src/kvrm_pkg.sv
// Package for the key/value record matcher: selector and status codes,
// character constants and the ASCII case fold.
// No dependencies; imported by key_value_record_matcher_top.
`default_nettype none
package kvrm_pkg;

  localparam int DATA_W = 8;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int FIELD_W = 15;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_W = 16;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [DATA_W-1:0] byte_t;

  localparam func_t FUNC_START = 2'd0;
  localparam func_t FUNC_NAME  = 2'd1;
  localparam func_t FUNC_BLOCK = 2'd2;

  localparam status_t ST_FOUND     = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_BAD_BLOCK = 2'd2;
  localparam status_t ST_INVALID   = 2'd3;

  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_EQUAL = 8'h3d;
  localparam byte_t CH_LOW_A = 8'h61;
  localparam byte_t CH_LOW_Z = 8'h7a;
  localparam byte_t CASE_OFS = 8'h20;

  localparam logic [CFG_W-1:0] SCAN_LIMIT_RESET = 16'h8000;

  function automatic byte_t fold_upper(input byte_t b);
    byte_t r;
    r = b;
    if (b >= CH_LOW_A && b <= CH_LOW_Z) begin
      r = b - CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/key_value_record_matcher_top.sv
// Key/value record matcher: looks up one NAME=value entry in a streamed
// environment block. Uses kvrm_pkg and one kvrm_ram for the wanted name.
//
// Input channel (in_*): one transaction per byte. in_tuser selects the kind:
// start a new search, append a name byte, or an environment block byte; any
// other selector is ignored. in_tdata carries the byte.
// Result channel (out_*): at most one transaction per search. out_tuser holds
// the status (found, not found, bad block, invalid argument); out_tdata holds
// the value offset and length, both zero unless the status is found.
// cfg_wr_en/cfg_wr_data write the scan limit; write it only while idle.
// A result appears on out_tvalid in the cycle after the input transaction
// that caused it. Throughput is one input byte per cycle while in_tready is
// high, set by the loop through the search state and the name RAM read, whose
// address is taken from the next entry-name position.
// While a result waits and out_tready is low, in_tready drops until it is
// taken. Reset clears the search state, empties the output register and sets
// the scan limit to 32768; the name RAM keeps old contents, only bytes
// written in the current search are ever compared.
`default_nettype none
module key_value_record_matcher_top #(
  parameter int MAX_NAME_BYTES  = 127,
  parameter int MAX_BLOCK_BYTES = 32768
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [kvrm_pkg::DATA_W-1:0]      in_tdata,   // [7:0] data
  input  wire  [kvrm_pkg::FUNC_W-1:0]      in_tuser,   // [1:0] func
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [kvrm_pkg::OUT_DATA_W-1:0]  out_tdata,  // [14:0] val_offset,
                                                       // [29:15] val_size,
                                                       // [31:30] zero
  output logic [kvrm_pkg::STAT_W-1:0]      out_tuser,  // [1:0] status
  input  wire                              cfg_wr_en,
  input  wire  [kvrm_pkg::CFG_W-1:0]       cfg_wr_data // scan_limit
);
  import kvrm_pkg::*;

  localparam int AW  = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
  localparam int NCW = $clog2(MAX_NAME_BYTES + 1);
  localparam int CW  = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int LW  = 17;
  localparam int PW  = 8;

  // Configuration
  logic [CFG_W-1:0] scan_limit_r;

  // Search state
  logic [NCW-1:0] name_count_r, name_count_nxt;
  logic           name_invalid_r, name_invalid_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;
  logic           entry_begin_r, entry_begin_nxt;
  logic [PW-1:0]  name_pos_r, name_pos_nxt;
  logic           seen_equal_r, seen_equal_nxt;
  logic           still_matching_r, still_matching_nxt;
  logic [CW-1:0]  value_begin_r, value_begin_nxt;
  logic [CW-1:0]  value_count_r, value_count_nxt;
  logic           finished_r, finished_nxt;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  status_t               out_status_r;

  logic                  emit;
  status_t               emit_status;
  logic [FIELD_W-1:0]    emit_start;
  logic [FIELD_W-1:0]    emit_len;

  // Name store
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [AW-1:0] ram_rd_addr;
  byte_t         ram_rd_data;
  logic          byp_r;
  byte_t         byp_data_r;
  byte_t         name_byte;

  logic   accept;
  func_t  func;
  byte_t  b;
  logic [LW-1:0] limit;
  logic [CW:0]   cursor_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign func      = in_tuser;
  assign b         = in_tdata;

  assign limit = (LW'(scan_limit_r) > LW'(MAX_BLOCK_BYTES)) ? LW'(MAX_BLOCK_BYTES)
                                                          : LW'(scan_limit_r);
  assign cursor_inc = (CW + 1)'(cursor_r) + 1'b1;

  assign ram_wr_en   = accept && (func == FUNC_NAME) && !finished_r &&
                       (cursor_r == '0) &&
                       (NCW'(name_count_r) < NCW'(MAX_NAME_BYTES));
  assign ram_wr_addr = name_count_r[AW-1:0];
  // Read from the next entry-name position so the byte at the current one is ready.
  assign ram_rd_addr = AW'(name_pos_nxt);
  assign name_byte   = byp_r ? byp_data_r : ram_rd_data;

  kvrm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_NAME_BYTES)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (b),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    name_count_nxt     = name_count_r;
    name_invalid_nxt   = name_invalid_r;
    cursor_nxt         = cursor_r;
    entry_begin_nxt    = entry_begin_r;
    name_pos_nxt       = name_pos_r;
    seen_equal_nxt     = seen_equal_r;
    still_matching_nxt = still_matching_r;
    value_begin_nxt    = value_begin_r;
    value_count_nxt    = value_count_r;
    finished_nxt       = finished_r;
    emit               = 1'b0;
    emit_status        = ST_FOUND;
    emit_start         = '0;
    emit_len           = '0;

    if (accept) begin
      case (func)
        FUNC_START: begin
          name_count_nxt     = '0;
          name_invalid_nxt   = 1'b0;
          cursor_nxt         = '0;
          finished_nxt       = 1'b0;
          entry_begin_nxt    = 1'b1;
          name_pos_nxt       = '0;
          seen_equal_nxt     = 1'b0;
          still_matching_nxt = 1'b1;
          value_begin_nxt    = '0;
          value_count_nxt    = '0;
        end
        FUNC_NAME: begin
          if (!finished_r && cursor_r == '0) begin
            if (b == CH_NUL || b == CH_EQUAL) begin
              name_invalid_nxt = 1'b1;
            end
            if (NCW'(name_count_r) >= NCW'(MAX_NAME_BYTES)) begin
              name_invalid_nxt = 1'b1;
            end else begin
              name_count_nxt = name_count_r + 1'b1;
            end
          end
        end
        FUNC_BLOCK: begin
          if (!finished_r) begin
            if (name_invalid_r || name_count_r == '0) begin
              emit        = 1'b1;
              emit_status = ST_INVALID;
            end else if (LW'(cursor_r) >= limit) begin
              emit        = 1'b1;
              emit_status = ST_BAD_BLOCK;
            end else if (entry_begin_r && b == CH_NUL) begin
              emit        = 1'b1;
              emit_status = ST_NOT_FOUND;
            end else begin
              entry_begin_nxt = 1'b0;
              cursor_nxt      = cursor_inc[CW-1:0];
              if (b == CH_NUL) begin
                if (seen_equal_r && still_matching_r) begin
                  emit        = 1'b1;
                  emit_status = ST_FOUND;
                  emit_start  = FIELD_W'(value_begin_r);
                  emit_len    = FIELD_W'(value_count_r);
                end else begin
                  // End of a non-matching entry: get ready for the next one.
                  entry_begin_nxt    = 1'b1;
                  name_pos_nxt       = '0;
                  seen_equal_nxt     = 1'b0;
                  still_matching_nxt = 1'b1;
                  value_begin_nxt    = '0;
                  value_count_nxt    = '0;
                end
              end else if (!seen_equal_r && b == CH_EQUAL) begin
                seen_equal_nxt     = 1'b1;
                still_matching_nxt = still_matching_r &&
                                     (name_pos_r == PW'(name_count_r));
                value_begin_nxt    = cursor_inc[CW-1:0];
              end else if (!seen_equal_r) begin
                if (name_pos_r >= PW'(name_count_r) ||
                    name_pos_r >= PW'(MAX_NAME_BYTES) ||
                    fold_upper(b) != fold_upper(name_byte)) begin
                  still_matching_nxt = 1'b0;
                end
                if (name_pos_r != '1) begin
                  name_pos_nxt = name_pos_r + 1'b1;
                end
              end else if (still_matching_r) begin
                value_count_nxt = value_count_r + 1'b1;
              end
            end
            if (emit) begin
              finished_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r     <= SCAN_LIMIT_RESET;
      name_count_r     <= '0;
      name_invalid_r   <= 1'b0;
      cursor_r         <= '0;
      entry_begin_r    <= 1'b1;
      name_pos_r       <= '0;
      seen_equal_r     <= 1'b0;
      still_matching_r <= 1'b1;
      value_begin_r    <= '0;
      value_count_r    <= '0;
      finished_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      byp_r            <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scan_limit_r <= cfg_wr_data;
      end
      name_count_r     <= name_count_nxt;
      name_invalid_r   <= name_invalid_nxt;
      cursor_r         <= cursor_nxt;
      entry_begin_r    <= entry_begin_nxt;
      name_pos_r       <= name_pos_nxt;
      seen_equal_r     <= seen_equal_nxt;
      still_matching_r <= still_matching_nxt;
      value_begin_r    <= value_begin_nxt;
      value_count_r    <= value_count_nxt;
      finished_r       <= finished_nxt;
      // A write to the address being read returns old RAM data; forward it.
      byp_r            <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= b;
    if (emit) begin
      out_status_r <= emit_status;
      out_data_r   <= {{(OUT_DATA_W - 2 * FIELD_W){1'b0}}, emit_len, emit_start};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

>>> src/kvrm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read in the same cycle as a write to that address returns the old data.
// No dependencies.
`default_nettype none
module kvrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  wire                             clk,
  input  wire                             wr_en,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire [WIDTH-1:0]                 wr_data,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for key_value_record_matcher_top: streams name and
// environment-block bytes and scores each lookup result against a local model.
// Depends on kvrm_pkg and key_value_record_matcher_top from src.
`default_nettype none
module tb;
  import kvrm_pkg::*;

  localparam func_t FUNC_NOP = 2'd3;
  localparam int NAME_MAX = 127;
  localparam int BLOCK_MAX = 32768;
  localparam int NAME_POS_CAP = 255;
  localparam int RANDOM_ITEMS = 920;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   start;
    logic [FIELD_W-1:0]   length;
  } lookup_result_t;

  typedef struct packed {
    func_t          f;
    byte_t          d;
    logic           typed;
    lookup_result_t res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;

  // Lookup model state.
  byte_t                  want_name [NAME_MAX];
  int                     want_len;
  bit                     want_bad;
  int                     scan_pos;
  bit                     at_entry_start;
  int                     entry_name_pos;
  bit                     past_equal;
  bit                     entry_ok;
  int                     val_begin;
  int                     val_len;
  bit                     search_done;
  logic [CFG_W-1:0]       limit_reg;
  bit                     step_hit;
  lookup_result_t         step_res;

  lookup_result_t         pending_results [$];
  lookup_result_t         head;
  int                     mismatches = 0;
  int                     items_sent = 0;
  int                     hold_cycles = 0;
  bit                     tx_idle = 1'b1;
  bit                     rx_idle = 1'b1;

  dir_row_t dir_rows [0:23] = '{
    '{FUNC_BLOCK, 8'h41, 1'b1, '{ST_INVALID, 15'd0, 15'd0}},   // no name yet
    '{FUNC_START, 8'h00, 1'b0, '0},
    '{FUNC_NAME,  8'h70, 1'b0, '0},                            // "pA"
    '{FUNC_NAME,  8'h41, 1'b0, '0},
    '{FUNC_NOP,   8'hff, 1'b0, '0},
    '{FUNC_BLOCK, 8'h50, 1'b0, '0},                            // "Pa=\xff="
    '{FUNC_NAME,  8'h5a, 1'b0, '0},                            // late, ignored
    '{FUNC_BLOCK, 8'h61, 1'b0, '0},
    '{FUNC_BLOCK, 8'h3d, 1'b0, '0},
    '{FUNC_BLOCK, 8'hff, 1'b0, '0},
    '{FUNC_BLOCK, 8'h3d, 1'b0, '0},
    '{FUNC_BLOCK, 8'h00, 1'b1, '{ST_FOUND, 15'd3, 15'd2}},
    '{FUNC_BLOCK, 8'h00, 1'b0, '0},                            // after result
    '{FUNC_NAME,  8'h71, 1'b0, '0},
    '{FUNC_START, 8'hff, 1'b0, '0},
    '{FUNC_NAME,  8'h3d, 1'b0, '0},
    '{FUNC_BLOCK, 8'h78, 1'b1, '{ST_INVALID, 15'd0, 15'd0}},
    '{FUNC_START, 8'h00, 1'b0, '0},
    '{FUNC_NAME,  8'h00, 1'b0, '0},
    '{FUNC_BLOCK, 8'h00, 1'b1, '{ST_INVALID, 15'd0, 15'd0}},
    '{FUNC_START, 8'h00, 1'b0, '0},
    '{FUNC_NAME,  8'h7a, 1'b0, '0},
    '{FUNC_BLOCK, 8'h00, 1'b1, '{ST_NOT_FOUND, 15'd0, 15'd0}},
    '{FUNC_BLOCK, 8'h5a, 1'b0, '0}
  };

  key_value_record_matcher_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic byte_t upcase(input byte_t b);
    return (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_OFS : b;
  endfunction

  function automatic byte_t flip_case(input byte_t b);
    byte_t u;
    u = upcase(b);
    if (u >= 8'h41 && u <= 8'h5a && $urandom_range(0, 1) == 1) begin
      return b ^ CASE_OFS;
    end
    return b;
  endfunction

  // Mostly letters and the bytes just outside the letter ranges, so that the
  // case fold boundaries get exercised.
  function automatic byte_t name_char();
    byte_t pool [0:9];
    byte_t b;
    pool = '{8'h41, 8'h5a, 8'h61, 8'h7a, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h5f, 8'h42};
    if ($urandom_range(0, 7) == 0) begin
      do b = byte_t'($urandom_range(1, 255)); while (b == CH_EQUAL);
    end else begin
      b = pool[$urandom_range(0, 9)];
    end
    return b;
  endfunction

  function automatic void clear_entry();
    at_entry_start = 1'b1;
    entry_name_pos = 0;
    past_equal = 1'b0;
    entry_ok = 1'b1;
    val_begin = 0;
    val_len = 0;
  endfunction

  function automatic void clear_search();
    want_len = 0;
    want_bad = 1'b0;
    scan_pos = 0;
    search_done = 1'b0;
    clear_entry();
  endfunction

  function automatic void close_search(input status_t s, input int st, input int ln);
    step_hit = 1'b1;
    step_res.status = s;
    step_res.start = st[FIELD_W-1:0];
    step_res.length = ln[FIELD_W-1:0];
    search_done = 1'b1;
  endfunction

  // Advances the lookup model by one accepted transaction.
  function automatic void lookup_step(input func_t f, input byte_t d);
    int eff_limit;
    step_hit = 1'b0;
    step_res = '0;
    eff_limit = (int'(limit_reg) > BLOCK_MAX) ? BLOCK_MAX : int'(limit_reg);
    case (f)
      FUNC_START: begin
        clear_search();
      end
      FUNC_NAME: begin
        if (!search_done && scan_pos == 0) begin
          if (d == CH_NUL || d == CH_EQUAL) want_bad = 1'b1;
          if (want_len >= NAME_MAX) begin
            want_bad = 1'b1;
          end else begin
            want_name[want_len] = d;
            want_len++;
          end
        end
      end
      FUNC_BLOCK: begin
        if (search_done) begin
        end else if (want_bad || want_len == 0) begin
          close_search(ST_INVALID, 0, 0);
        end else if (scan_pos >= eff_limit) begin
          close_search(ST_BAD_BLOCK, 0, 0);
        end else if (at_entry_start && d == CH_NUL) begin
          close_search(ST_NOT_FOUND, 0, 0);
        end else begin
          at_entry_start = 1'b0;
          scan_pos++;
          if (d == CH_NUL) begin
            if (past_equal && entry_ok) close_search(ST_FOUND, val_begin, val_len);
            else clear_entry();
          end else if (!past_equal && d == CH_EQUAL) begin
            past_equal = 1'b1;
            entry_ok = entry_ok && (entry_name_pos == want_len);
            val_begin = scan_pos;
          end else if (!past_equal) begin
            if (entry_name_pos >= want_len || entry_name_pos >= NAME_MAX ||
                upcase(d) != upcase(want_name[entry_name_pos])) begin
              entry_ok = 1'b0;
            end
            if (entry_name_pos < NAME_POS_CAP) entry_name_pos++;
          end else if (entry_ok) begin
            val_len++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want_v);
    if (mismatches < PRINT_CAP) begin
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want_v);
    end
    mismatches++;
  endtask

  // Offers one transaction and waits until it is accepted.
  task automatic push_byte(input func_t f, input byte_t d, input logic typed = 1'b0,
                           input lookup_result_t typed_res = '0);
    if (tx_idle && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lookup_step(f, d);
    if (typed) pending_results.push_back(typed_res);
    else if (step_hit) pending_results.push_back(step_res);
    items_sent++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report("results never arrived", 0, pending_results.size());
      pending_results.delete();
    end
  endtask

  // The block may still be working on a byte that produces no result, so the
  // task idles after the drain before the register changes.
  task automatic set_limit(input logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  task automatic random_search();
    byte_t wanted [$];
    byte_t entry [$];
    int n, e, j, nent, shape, vlen;
    push_byte(FUNC_START, byte_t'($urandom_range(0, 255)));
    shape = $urandom_range(0, 19);
    n = (shape == 0) ? 0 : $urandom_range(1, 5);
    for (j = 0; j < n; j++) wanted.push_back(name_char());
    if (shape == 1) wanted[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ? CH_NUL : CH_EQUAL;
    foreach (wanted[k]) push_byte(FUNC_NAME, wanted[k]);
    nent = $urandom_range(0, 4);
    for (e = 0; e < nent; e++) begin
      entry.delete();
      shape = $urandom_range(0, 9);
      if (shape <= 5) begin
        // Exact name, a name one byte short, or one byte long.
        for (j = 0; j < n; j++) begin
          if (!(shape == 4 && j == n - 1)) entry.push_back(flip_case(wanted[j]));
        end
        if (shape == 5) entry.push_back(name_char());
      end else begin
        repeat ($urandom_range(1, 5)) entry.push_back(name_char());
      end
      // An entry without '=' can never match.
      if (shape != 6) entry.push_back(CH_EQUAL);
      vlen = $urandom_range(0, 6);
      repeat (vlen) entry.push_back(byte_t'($urandom_range(1, 255)));
      entry.push_back(CH_NUL);
      foreach (entry[k]) begin
        if ($urandom_range(0, 24) == 0) begin
          push_byte($urandom_range(0, 1) ? FUNC_NOP : FUNC_NAME, byte_t'($urandom_range(0, 255)));
        end
        push_byte(FUNC_BLOCK, entry[k]);
      end
    end
    if ($urandom_range(0, 3) != 0) push_byte(FUNC_BLOCK, CH_NUL);
    repeat ($urandom_range(0, 2)) begin
      push_byte(func_t'($urandom_range(1, 3)), byte_t'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stalls, plus one long hold requested by the stimulus.
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, status", out_tuser, -1);
      end else begin
        head = pending_results.pop_front();
        if (out_tuser !== head.status) report("status", out_tuser, head.status);
        if (out_tdata[FIELD_W-1:0] !== head.start) begin
          report("val_offset", out_tdata[FIELD_W-1:0], head.start);
        end
        if (out_tdata[2*FIELD_W-1:FIELD_W] !== head.length) begin
          report("val_size", out_tdata[2*FIELD_W-1:FIELD_W], head.length);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("key_value_record_matcher_top verification failed");
    $finish;
  end

  initial begin
    int ph, goal;
    logic [CFG_W-1:0] lim;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    limit_reg = SCAN_LIMIT_RESET;
    clear_search();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) push_byte(dir_rows[r].f, dir_rows[r].d, dir_rows[r].typed,
                                     dir_rows[r].res);

    // Smallest limits: one byte may be scanned, then none at all.
    set_limit(16'd1);
    push_byte(FUNC_START, 8'h00);
    push_byte(FUNC_NAME, 8'h41);
    push_byte(FUNC_BLOCK, 8'h41);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    set_limit(16'd0);
    push_byte(FUNC_START, 8'h00);
    push_byte(FUNC_NAME, 8'h41);
    push_byte(FUNC_BLOCK, 8'h41);

    // A limit above the block size must not cut an ordinary search short.
    set_limit(16'hffff);
    push_byte(FUNC_START, 8'h00);
    push_byte(FUNC_NAME, 8'h4b);
    push_byte(FUNC_BLOCK, 8'h58);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    push_byte(FUNC_BLOCK, 8'h31);
    push_byte(FUNC_BLOCK, CH_NUL);
    push_byte(FUNC_BLOCK, 8'h6b);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    repeat (20) push_byte(FUNC_BLOCK, byte_t'($urandom_range(1, 255)));
    push_byte(FUNC_BLOCK, CH_NUL);

    // A long value under the reset limit.
    set_limit(SCAN_LIMIT_RESET);
    push_byte(FUNC_START, 8'h00);
    push_byte(FUNC_NAME, 8'h76);
    push_byte(FUNC_BLOCK, 8'h56);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    repeat (100) push_byte(FUNC_BLOCK, byte_t'($urandom_range(1, 255)));
    push_byte(FUNC_BLOCK, CH_NUL);

    // Name one byte too long, then a name of exactly the maximum length.
    push_byte(FUNC_START, 8'h00);
    repeat (NAME_MAX + 1) push_byte(FUNC_NAME, 8'h41);
    push_byte(FUNC_BLOCK, 8'h41);
    push_byte(FUNC_START, 8'h00);
    repeat (NAME_MAX) push_byte(FUNC_NAME, 8'h61);
    repeat (NAME_MAX) push_byte(FUNC_BLOCK, 8'h41);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    push_byte(FUNC_BLOCK, 8'h76);
    push_byte(FUNC_BLOCK, CH_NUL);

    // An entry name longer than the position counter can hold.
    push_byte(FUNC_START, 8'h00);
    push_byte(FUNC_NAME, 8'h41);
    repeat (300) push_byte(FUNC_BLOCK, 8'h41);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    push_byte(FUNC_BLOCK, 8'h76);
    push_byte(FUNC_BLOCK, CH_NUL);
    push_byte(FUNC_BLOCK, 8'h61);
    push_byte(FUNC_BLOCK, CH_EQUAL);
    push_byte(FUNC_BLOCK, 8'h77);
    push_byte(FUNC_BLOCK, CH_NUL);

    // Back-to-back short searches while the result side holds off, so the
    // output register fills and the input side has to stall.
    drain();
    hold_cycles = 400;
    repeat (30) begin
      push_byte(FUNC_START, 8'h00);
      push_byte(FUNC_NAME, name_char());
      push_byte(FUNC_BLOCK, CH_NUL);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: lim = SCAN_LIMIT_RESET;
        1: lim = CFG_W'($urandom_range(8, 40));
        2: lim = CFG_W'($urandom_range(1, 65535));
        default: lim = SCAN_LIMIT_RESET;
      endcase
      set_limit(lim);
      tx_idle = (ph != 3);
      rx_idle = (ph != 3);
      goal = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < goal) random_search();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("key_value_record_matcher_top verification clean");
    end else begin
      $display("key_value_record_matcher_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
